// ===== rtl/core/sorted_table_block_prefix_encoder_unit_macros.svh =====
// Assertion macros used by the encoder unit's RTL file.
`ifndef SORTED_TABLE_BLOCK_PREFIX_ENCODER_UNIT_MACROS_SVH
`define SORTED_TABLE_BLOCK_PREFIX_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define STBPE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define STBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stbpe_pkg.sv =====
// Shared types and constants of the sorted table block prefix encoder.
package stbpe_pkg;

    localparam int MAX_KEY_BYTES_DEF = 256;
    localparam int MAX_RESTARTS_DEF  = 32;
    localparam logic [15:0] RESTART_INTERVAL_RST = 16'd16;
    localparam logic [31:0] HEADER_BYTES = 32'd12;

    typedef enum logic [1:0] {
        FUNC_KEY    = 2'd0,
        FUNC_VALUE  = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_SHARED     = 3'd0,
        KIND_NON_SHARED = 3'd1,
        KIND_VALUE_SIZE = 3'd2,
        KIND_KEY_BYTE   = 3'd3,
        KIND_VALUE_BYTE = 3'd4,
        KIND_RST_OFFSET = 3'd5,
        KIND_RST_COUNT  = 3'd6
    } t_kind;

endpackage

// ===== rtl/core/stbpe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module stbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/sorted_table_block_prefix_encoder_unit.sv =====
// Sorted table block builder: prefix-compressed keys, restart points, finish dump.
//
// Input stream (s_axis): one item per handshake. tuser carries the function
// (key byte, value byte, finish), tdata the byte and the entry's key and value
// lengths. Output stream (m_axis): header fields, key and value bytes, restart
// offsets and restart count; tlast marks the last result of one input item.
// Config channel (i_cfg_*): writes the restart interval; always ready, the new
// value applies to items accepted after the write.
// Items are handled one at a time; input is ready only while idle. A key or
// value item is read from memory, then evaluated, then emits one result per
// cycle while the output register is free: a plain key or value byte, or the
// header (shared, non-shared, value size), possibly followed by the key byte.
// The first result goes into the output register from the emit state. Finish
// reads each stored restart offset from memory, then outputs it, and ends with
// the count. Previous-key and restart-offset memories each have one read port.
// Reset (synchronous, active low) clears the control state and sets the
// interval to 16; no memory clearing pass is needed. When m_axis_tready is
// low the output register holds its result and the sequencer waits.
module sorted_table_block_prefix_encoder_unit #(
    parameter int MAX_KEY_BYTES = stbpe_pkg::MAX_KEY_BYTES_DEF,
    parameter int MAX_RESTARTS  = stbpe_pkg::MAX_RESTARTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_byte[7:0], key_length[16:8], value_length[32:17]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_value[31:0]
    output logic [3:0]  m_axis_tuser,  // out_kind[2:0], overflow[3]
    output logic        m_axis_tlast
);

    localparam int KAW = $clog2(MAX_KEY_BYTES);
    localparam int RAW = $clog2(MAX_RESTARTS);
    localparam int TW  = $clog2(MAX_RESTARTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT,
        S_FRD,
        S_FOUT,
        S_FCNT
    } t_state;

    t_state r_state;

    // block state
    logic [15:0]   r_interval;
    logic [8:0]    r_prev_len;
    logic [8:0]    r_key_pos;
    logic          r_sm;
    logic [15:0]   r_entries;
    logic [TW-1:0] r_total;
    logic [31:0]   r_block_off;

    // latched item
    stbpe_pkg::t_func r_func;
    logic [7:0]       r_byte;
    logic [8:0]       r_klen;
    logic [15:0]      r_vlen;

    // result sequence of one item
    logic [1:0]       r_eidx;
    logic             r_do_key;
    logic             r_ovf;
    logic [8:0]       r_hdr_shared;
    logic [8:0]       r_hdr_ns;
    stbpe_pkg::t_kind r_byte_kind;
    logic [TW-1:0]    r_fi;

    // output register
    logic             r_out_valid;
    stbpe_pkg::t_kind r_out_kind;
    logic [31:0]      r_out_value;
    logic             r_out_ovf;
    logic             r_out_last;

    logic       accept;
    logic       out_free;
    logic       out_load;
    logic [7:0] key_rdata;
    logic [31:0] off_rdata;

    // evaluation of a key byte
    logic       e_restart;
    logic       e_ovf;
    logic       e_rs_wr;
    logic       e_in_key;
    logic       e_sm0;
    logic       e_same;
    logic       e_hdr_mid;
    logic       e_sm1;
    logic       e_key_out;
    logic [8:0] e_p1;
    logic       e_done;
    logic       e_hdr_end;
    logic       e_do_hdr;
    logic [8:0] e_shared;
    logic [8:0] e_ns;
    logic       e_key_wr;
    logic [8:0] e_prev_len;
    logic [31:0] e_boff;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    // the output register takes a new result in this cycle
    assign out_load      = out_free && ((r_state == S_EMIT) || (r_state == S_FOUT)
                                        || (r_state == S_FCNT));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = {r_out_ovf, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        e_restart = (r_key_pos == 9'd0) && (r_entries >= r_interval);
        e_ovf     = e_restart && (r_total >= TW'(MAX_RESTARTS));
        e_rs_wr   = e_restart && !e_ovf;
        e_in_key  = r_key_pos < r_klen;
        e_sm0     = e_restart ? 1'b0 : r_sm;
        // prev_len never exceeds the memory depth, so this also bounds the read
        e_same    = (r_key_pos < r_prev_len) && (key_rdata == r_byte);
        e_hdr_mid = e_in_key && e_sm0 && !e_same;
        e_sm1     = e_sm0 && !e_hdr_mid;
        e_key_out = e_in_key && !e_sm1;
        e_p1      = e_in_key ? (r_key_pos + 9'd1) : r_key_pos;
        e_done    = e_p1 >= r_klen;
        e_hdr_end = e_done && e_sm1;
        e_do_hdr  = e_restart || e_hdr_mid || e_hdr_end;
        if (e_restart) begin
            e_shared = 9'd0;
        end else if (e_hdr_mid) begin
            e_shared = r_key_pos;
        end else begin
            e_shared = e_p1;
        end
        e_ns       = (r_klen > e_shared) ? (r_klen - e_shared) : 9'd0;
        e_key_wr   = e_in_key && (32'(r_key_pos) < MAX_KEY_BYTES);
        e_prev_len = (32'(e_p1) < MAX_KEY_BYTES) ? e_p1 : 9'(MAX_KEY_BYTES);
        e_boff     = r_block_off + (e_do_hdr ? stbpe_pkg::HEADER_BYTES : 32'd0)
                   + (e_key_out ? 32'd1 : 32'd0);
    end

    stbpe_ram #(
        .WIDTH(8),
        .DEPTH(MAX_KEY_BYTES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == S_EVAL) && (r_func == stbpe_pkg::FUNC_KEY) && e_key_wr),
        .i_wr_addr (KAW'(r_key_pos)),
        .i_wr_data (r_byte),
        .i_rd_en   (accept),
        .i_rd_addr (KAW'(r_key_pos)),
        .o_rd_data (key_rdata)
    );

    stbpe_ram #(
        .WIDTH(32),
        .DEPTH(MAX_RESTARTS)
    ) u_off_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == S_EVAL) && (r_func == stbpe_pkg::FUNC_KEY) && e_rs_wr),
        .i_wr_addr (RAW'(r_total)),
        .i_wr_data (r_block_off),
        .i_rd_en   (r_state == S_FRD),
        .i_rd_addr (RAW'(r_fi)),
        .o_rd_data (off_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= stbpe_pkg::RESTART_INTERVAL_RST;
            r_prev_len  <= '0;
            r_key_pos   <= '0;
            r_sm        <= 1'b1;
            r_entries   <= '0;
            r_total     <= TW'(1);
            r_block_off <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func  <= stbpe_pkg::t_func'(s_axis_tuser);
                        r_byte  <= s_axis_tdata[7:0];
                        r_klen  <= s_axis_tdata[16:8];
                        r_vlen  <= s_axis_tdata[32:17];
                        r_state <= S_EVAL;
                    end
                end

                S_EVAL: begin
                    unique case (r_func)
                        stbpe_pkg::FUNC_KEY: begin
                            r_ovf        <= e_ovf;
                            r_hdr_shared <= e_shared;
                            r_hdr_ns     <= e_ns;
                            r_do_key     <= e_key_out;
                            r_byte_kind  <= stbpe_pkg::KIND_KEY_BYTE;
                            r_block_off  <= e_boff;
                            if (e_rs_wr) begin
                                r_total <= r_total + TW'(1);
                            end
                            if (e_done) begin
                                r_prev_len <= e_prev_len;
                                r_key_pos  <= '0;
                                r_sm       <= 1'b1;
                                if (e_restart) begin
                                    r_entries <= 16'd1;
                                end else if (r_entries != 16'hFFFF) begin
                                    r_entries <= r_entries + 16'd1;
                                end
                            end else begin
                                r_key_pos <= e_p1;
                                r_sm      <= e_sm1;
                                if (e_restart) begin
                                    r_entries <= '0;
                                end
                            end
                            if (e_do_hdr) begin
                                r_eidx  <= 2'd0;
                                r_state <= S_EMIT;
                            end else if (e_key_out) begin
                                r_eidx  <= 2'd3;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        stbpe_pkg::FUNC_VALUE: begin
                            r_ovf       <= 1'b0;
                            r_do_key    <= 1'b1;
                            r_byte_kind <= stbpe_pkg::KIND_VALUE_BYTE;
                            r_block_off <= r_block_off + 32'd1;
                            r_eidx      <= 2'd3;
                            r_state     <= S_EMIT;
                        end
                        stbpe_pkg::FUNC_FINISH: begin
                            r_fi    <= '0;
                            r_state <= S_FRD;
                        end
                        stbpe_pkg::FUNC_NOP: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out_ovf   <= r_ovf;
                        r_out_last  <= (r_eidx == 2'd3) || ((r_eidx == 2'd2) && !r_do_key);
                        unique case (r_eidx)
                            2'd0: begin
                                r_out_kind  <= stbpe_pkg::KIND_SHARED;
                                r_out_value <= 32'(r_hdr_shared);
                            end
                            2'd1: begin
                                r_out_kind  <= stbpe_pkg::KIND_NON_SHARED;
                                r_out_value <= 32'(r_hdr_ns);
                            end
                            2'd2: begin
                                r_out_kind  <= stbpe_pkg::KIND_VALUE_SIZE;
                                r_out_value <= 32'(r_vlen);
                            end
                            2'd3: begin
                                r_out_kind  <= r_byte_kind;
                                r_out_value <= 32'(r_byte);
                            end
                        endcase
                        if ((r_eidx == 2'd3) || ((r_eidx == 2'd2) && !r_do_key)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_eidx <= r_eidx + 2'd1;
                        end
                    end
                end

                S_FRD: begin
                    r_state <= S_FOUT;
                end

                S_FOUT: begin
                    if (out_free) begin
                        r_out_kind  <= stbpe_pkg::KIND_RST_OFFSET;
                        // entry zero is always offset zero and is never written
                        r_out_value <= (r_fi == '0) ? 32'd0 : off_rdata;
                        r_out_ovf   <= 1'b0;
                        r_out_last  <= 1'b0;
                        r_fi        <= r_fi + TW'(1);
                        r_state     <= ((r_fi + TW'(1)) == r_total) ? S_FCNT : S_FRD;
                    end
                end

                S_FCNT: begin
                    if (out_free) begin
                        r_out_kind  <= stbpe_pkg::KIND_RST_COUNT;
                        r_out_value <= 32'(r_total);
                        r_out_ovf   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_prev_len  <= '0;
                        r_key_pos   <= '0;
                        r_sm        <= 1'b1;
                        r_entries   <= '0;
                        r_total     <= TW'(1);
                        r_block_off <= '0;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "sorted_table_block_prefix_encoder_unit_macros.svh"

    `STBPE_ASSERT_SAME(a_total_range, i_clk, i_rst_n, 1'b1, ((r_total != '0) && (32'(r_total) <= MAX_RESTARTS)), "restart count out of range")
    `STBPE_ASSERT_SAME(a_prev_len_bound, i_clk, i_rst_n, 1'b1, (32'(r_prev_len) <= MAX_KEY_BYTES), "stored key length exceeds memory depth")
    `STBPE_ASSERT_SAME(a_entry_start_matching, i_clk, i_rst_n, (r_key_pos == 9'd0), r_sm, "entry starts without match tracking")
    `STBPE_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, ((r_state == S_FCNT) && out_free), ((r_total == TW'(1)) && (r_block_off == 32'd0) && r_out_last), "finish did not clear the block")

endmodule
